@@ rtl/core/stip_pkg.sv @@
// Shared types, constants and register codes for the string-to-integer parser.
package stip_pkg;

  // Default widths and sizes
  localparam int OFFSET_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_ADDR_BITS   = 5;
  localparam int CFG_DATA_BITS   = 64;
  localparam int RESULT_OFF_BITS = 16;

  // Register indexes (byte address = 8 * index)
  localparam logic [1:0] REG_RADIX       = 2'd0;
  localparam logic [1:0] REG_POS_LIMIT   = 2'd1;
  localparam logic [1:0] REG_NEG_LIMIT   = 2'd2;
  localparam logic [1:0] REG_DIGIT_LIMIT = 2'd3;

  // Register reset values
  localparam logic [5:0]  RADIX_RST       = 6'd0;
  localparam logic [63:0] POS_LIMIT_RST   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT_RST   = 64'h8000_0000_0000_0000;
  localparam logic [6:0]  DIGIT_LIMIT_RST = 7'd19;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_BASE  = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  // Bases and digit codes
  localparam logic [5:0] NO_DIGIT  = 6'd36;
  localparam logic [5:0] MAX_BASE  = 6'd36;
  localparam logic [5:0] BASE_ONE  = 6'd1;
  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] LETTER_OFS = 6'd10;
  localparam logic [6:0] COUNT_MAX = 7'h7F;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  // Input word
  typedef struct packed {
    logic       start_req;
    logic [7:0] ch;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [15:0] end_offset;
  } out_word_t;

  // Classified character as queued between front and engine
  typedef struct packed {
    logic       start;
    logic       space;
    logic       minus;
    logic       plus;
    logic       zero;
    logic       x;
    logic [5:0] dval;
  } cls_t;

  // Configuration registers
  typedef struct packed {
    logic [5:0]  radix;
    logic [63:0] positive_limit;
    logic [63:0] negative_limit;
    logic [6:0]  digit_limit;
  } cfg_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/core/stip_front.sv @@
// Front end: accepts characters and classifies them for the parse engine.
module stip_front (
  input  logic              item_valid,
  output logic              item_ready,
  input  stip_pkg::in_word_t item,
  input  stip_pkg::q_stat_t q_stat,
  output logic              q_push,
  output stip_pkg::cls_t    cls
);

  logic [7:0] c;

  assign c          = item.ch;
  assign item_ready = !q_stat.full;
  assign q_push     = item_valid && item_ready;

  // Classify the character and work out its raw digit value
  always_comb begin
    cls.start = item.start_req;
    cls.space = (c == stip_pkg::CH_SPACE) || (c >= stip_pkg::CH_TAB && c <= stip_pkg::CH_CR);
    cls.minus = (c == stip_pkg::CH_MINUS);
    cls.plus  = (c == stip_pkg::CH_PLUS);
    cls.zero  = (c == stip_pkg::CH_ZERO);
    cls.x     = (c == stip_pkg::CH_LX) || (c == stip_pkg::CH_UX);
    if (c >= stip_pkg::CH_ZERO && c <= stip_pkg::CH_NINE) begin
      cls.dval = 6'(c - stip_pkg::CH_ZERO);
    end else if (c >= stip_pkg::CH_LA && c <= stip_pkg::CH_LZ) begin
      cls.dval = 6'(c - stip_pkg::CH_LA) + stip_pkg::LETTER_OFS;
    end else if (c >= stip_pkg::CH_UA && c <= stip_pkg::CH_UZ) begin
      cls.dval = 6'(c - stip_pkg::CH_UA) + stip_pkg::LETTER_OFS;
    end else begin
      cls.dval = stip_pkg::NO_DIGIT;
    end
  end

endmodule

@@ rtl/core/stip_queue.sv @@
// Short queue of classified characters between front end and parse engine.
module stip_queue #(
  parameter int DEPTH = stip_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stip_pkg::cls_t    wr_word,
  input  logic              pop,
  output logic              rd_valid,
  output stip_pkg::cls_t    rd_word,
  output stip_pkg::q_stat_t stat
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  stip_pkg::cls_t      mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign rd_valid   = !stat.empty;
  assign rd_word    = mem[rd_ptr];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  // Store incoming words
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_word;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/stip_back.sv @@
// Parse engine: sign, prefix and digit accumulation with range checks and result register.
module stip_back #(
  parameter int OFFSET_BITS = stip_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  stip_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  stip_pkg::cls_t      q_word,
  output logic                q_pop,
  output logic                result_valid,
  input  logic                result_ready,
  output stip_pkg::out_word_t result
);

  localparam int EXT_BITS = (OFFSET_BITS > stip_pkg::RESULT_OFF_BITS) ?
                            OFFSET_BITS : stip_pkg::RESULT_OFF_BITS;

  typedef enum logic [2:0] {
    PH_WS,
    PH_PREFIX,
    PH_AFTER0,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t                 phase, phase_next, cur_phase;
  logic [63:0]            acc, acc_next, cur_acc;
  logic                   neg, neg_next, cur_neg;
  logic [5:0]             base, base_next, cur_base;
  logic [6:0]             dcount, dcount_next, cur_dcount;
  logic [OFFSET_BITS-1:0] position, position_next, cur_pos, pos_inc;

  logic                   fire;
  logic                   bad_base;
  logic                   run;
  logic                   prefix_ok;
  logic [5:0]             dig_base;
  logic [69:0]            mac;
  logic [63:0]            bound;
  logic                   emit;
  logic [63:0]            emit_val;
  logic [1:0]             emit_st;
  logic [OFFSET_BITS-1:0] emit_off;
  logic [EXT_BITS-1:0]    off_ext;
  logic [15:0]            off_sat;

  assign fire  = q_valid && (!result_valid || result_ready);
  assign q_pop = fire;

  // Start of string restarts the parse state
  always_comb begin
    if (q_word.start) begin
      cur_phase  = PH_WS;
      cur_acc    = '0;
      cur_neg    = 1'b0;
      cur_base   = '0;
      cur_dcount = '0;
      cur_pos    = '0;
    end else begin
      cur_phase  = phase;
      cur_acc    = acc;
      cur_neg    = neg;
      cur_base   = base;
      cur_dcount = dcount;
      cur_pos    = position;
    end
  end

  assign pos_inc  = (cur_pos == '1) ? cur_pos : cur_pos + 1'b1;
  assign bad_base = (cfg.radix == stip_pkg::BASE_ONE) || (cfg.radix > stip_pkg::MAX_BASE);
  assign bound    = cur_neg ? cfg.negative_limit : cfg.positive_limit;

  // Step the parse for one character
  always_comb begin
    phase_next    = cur_phase;
    acc_next      = cur_acc;
    neg_next      = cur_neg;
    base_next     = cur_base;
    dcount_next   = cur_dcount;
    position_next = cur_pos;
    emit          = 1'b0;
    emit_val      = '0;
    emit_st       = stip_pkg::ST_OK;
    emit_off      = '0;
    run           = 1'b0;
    dig_base      = cur_base;
    prefix_ok     = 1'b0;
    case (cur_phase)
      PH_WS: begin
        prefix_ok = (cfg.radix == stip_pkg::BASE_AUTO || cfg.radix == stip_pkg::BASE_OCT ||
                     cfg.radix == stip_pkg::BASE_HEX) && q_word.zero;
        base_next = cfg.radix;
        if (bad_base) begin
          emit    = 1'b1;
          emit_st = stip_pkg::ST_BAD_BASE;
        end else if (q_word.space) begin
          position_next = pos_inc;
        end else if (q_word.minus || q_word.plus) begin
          phase_next    = PH_PREFIX;
          neg_next      = q_word.minus;
          position_next = pos_inc;
        end else if (prefix_ok) begin
          phase_next    = PH_AFTER0;
          position_next = pos_inc;
        end else begin
          run      = 1'b1;
          dig_base = (cfg.radix == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_DEC : cfg.radix;
        end
      end
      PH_PREFIX: begin
        prefix_ok = (cur_base == stip_pkg::BASE_AUTO || cur_base == stip_pkg::BASE_OCT ||
                     cur_base == stip_pkg::BASE_HEX) && q_word.zero;
        if (prefix_ok) begin
          phase_next    = PH_AFTER0;
          position_next = pos_inc;
        end else begin
          run      = 1'b1;
          dig_base = (cur_base == stip_pkg::BASE_AUTO) ? stip_pkg::BASE_DEC : cur_base;
        end
      end
      PH_AFTER0: begin
        if (q_word.x) begin
          phase_next    = PH_DIGITS;
          base_next     = stip_pkg::BASE_HEX;
          position_next = pos_inc;
        end else begin
          run      = 1'b1;
          dig_base = (cur_base == stip_pkg::BASE_HEX) ? stip_pkg::BASE_HEX : stip_pkg::BASE_OCT;
        end
      end
      PH_DIGITS: begin
        run = 1'b1;
      end
      PH_DONE: begin
        run = 1'b0;
      end
      default: begin
        run = 1'b0;
      end
    endcase

    // Multiply-accumulate with exact overflow out of 64 bits
    mac = 70'(cur_acc) * 70'(dig_base) + 70'(q_word.dval);

    if (run) begin
      phase_next = PH_DIGITS;
      base_next  = dig_base;
      if (q_word.dval >= dig_base) begin
        emit     = 1'b1;
        emit_val = cur_neg ? (64'd0 - cur_acc) : cur_acc;
        emit_st  = stip_pkg::ST_OK;
        emit_off = cur_pos;
      end else if ((mac[69:64] != '0) || (mac[63:0] > bound) ||
                   (cur_dcount > cfg.digit_limit)) begin
        emit     = 1'b1;
        emit_val = cur_neg ? (64'd0 - cfg.negative_limit) : cfg.positive_limit;
        emit_st  = stip_pkg::ST_RANGE;
        emit_off = pos_inc;
      end else begin
        acc_next      = mac[63:0];
        dcount_next   = (cur_dcount == stip_pkg::COUNT_MAX) ? cur_dcount : cur_dcount + 1'b1;
        position_next = pos_inc;
      end
    end

    if (emit) begin
      phase_next = PH_DONE;
    end
  end

  // Saturate the end offset to the result field
  assign off_ext = EXT_BITS'(emit_off);
  assign off_sat = (off_ext > EXT_BITS'(16'hFFFF)) ? 16'hFFFF : off_ext[15:0];

  // Hold parse state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WS;
      acc          <= '0;
      neg          <= 1'b0;
      base         <= '0;
      dcount       <= '0;
      position     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        phase    <= phase_next;
        acc      <= acc_next;
        neg      <= neg_next;
        base     <= base_next;
        dcount   <= dcount_next;
        position <= position_next;
      end
      if (fire && emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result.value      <= emit_val;
      result.status     <= emit_st;
      result.end_offset <= off_sat;
    end
  end

endmodule

@@ rtl/core/string_to_integer_parser_top.sv @@
// A result word is loaded into the result register after the terminating character has
// passed through the queue; a result held at the output stalls the engine.
// Throughput: one character per cycle while no result is held at the output; the engine's
// combinational 64x6 multiply-add with its range compare sets that figure.
// A result may wait at the output while further characters are queued (queue depth
// QUEUE_DEPTH); reset is synchronous, restores register defaults and empties the queue.
module string_to_integer_parser_top #(
  parameter int OFFSET_BITS = stip_pkg::OFFSET_BITS_DEF,
  parameter int QUEUE_DEPTH = stip_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  stip_pkg::in_word_t                   item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output stip_pkg::out_word_t                  result,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [stip_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [stip_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [stip_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  stip_pkg::cfg_t    cfg;
  stip_pkg::cls_t    cls;
  stip_pkg::cls_t    q_word;
  stip_pkg::q_stat_t q_stat;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix          <= stip_pkg::RADIX_RST;
      cfg.positive_limit <= stip_pkg::POS_LIMIT_RST;
      cfg.negative_limit <= stip_pkg::NEG_LIMIT_RST;
      cfg.digit_limit    <= stip_pkg::DIGIT_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        stip_pkg::REG_RADIX:       cfg.radix          <= pwdata[5:0];
        stip_pkg::REG_POS_LIMIT:   cfg.positive_limit <= pwdata;
        stip_pkg::REG_NEG_LIMIT:   cfg.negative_limit <= pwdata;
        stip_pkg::REG_DIGIT_LIMIT: cfg.digit_limit    <= pwdata[6:0];
        default:                   cfg.radix          <= cfg.radix;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      stip_pkg::REG_RADIX:       prdata = 64'(cfg.radix);
      stip_pkg::REG_POS_LIMIT:   prdata = cfg.positive_limit;
      stip_pkg::REG_NEG_LIMIT:   prdata = cfg.negative_limit;
      stip_pkg::REG_DIGIT_LIMIT: prdata = 64'(cfg.digit_limit);
      default:                   prdata = '0;
    endcase
  end

  stip_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .cls        (cls)
  );

  stip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_word  (cls),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_word  (q_word),
    .stat     (q_stat)
  );

  stip_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Queue comes out of reset empty, so characters are taken at once
  a_ready_after_reset: assert property (@(posedge clk) rst |=> item_ready)
    else $error("item_ready low after reset");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == stip_pkg::ST_OK ||
                      result.status == stip_pkg::ST_BAD_BASE ||
                      result.status == stip_pkg::ST_RANGE))
    else $error("undefined status code");

  // An invalid base gives a zero value at offset zero
  a_bad_base_word: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == stip_pkg::ST_BAD_BASE) |->
      (result.value == '0 && result.end_offset == '0))
    else $error("invalid-base word carries data");

  // An empty queue cannot feed the engine
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !q_pop)
    else $error("engine took a word from an empty queue");

endmodule
